// ===== hdl/nvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared types and constants of the nearest vertex search block.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned DistW   = 50;
  localparam int unsigned IdxW    = 20;
  localparam int unsigned ObjW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DiffW-1:0]         mag_t;
  typedef logic [DistW-1:0]         dist_t;
  typedef logic [IdxW-1:0]          idx_t;
  typedef logic [ObjW-1:0]          obj_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;

  localparam cfg_idx_t CFG_QUERY_X = 2'd0;
  localparam cfg_idx_t CFG_QUERY_Y = 2'd1;
  localparam cfg_idx_t CFG_QUERY_Z = 2'd2;

  localparam dist_t DIST_EMPTY = {DistW{1'b1}};

  typedef struct packed {
    dist_t  dist_sq;
    obj_t   obj;
    idx_t   idx;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } nvs_item_t;

endpackage

// ===== hdl/nvs_front.sv =====
// ----------------------------------------------------------------------------
// nvs_front
// Accepts vertices, assigns the index within the object and squares the
// coordinate differences to the query point; sums them on the way out.
// ----------------------------------------------------------------------------
module nvs_front import nvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  coord_t    query_x_i,
  input  coord_t    query_y_i,
  input  coord_t    query_z_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  coord_t    vertex_x_i,
  input  coord_t    vertex_y_i,
  input  coord_t    vertex_z_i,
  input  obj_t      object_id_i,
  input  logic      first_i,
  input  logic      last_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nvs_item_t out_item_o
);

  logic   valid_q, valid_d;
  idx_t   cnt_q, cnt_d;
  dist_t  sq_x_q, sq_y_q, sq_z_q;
  obj_t   obj_q;
  idx_t   idx_q;
  coord_t x_q, y_q, z_q;
  logic   last_q;
  idx_t   idx;
  logic   take;
  mag_t   mag_x, mag_y, mag_z;

  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic [DiffW-1:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[DiffW-1] ? (~d + 1'b1) : d;
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign idx        = first_i ? '0 : cnt_q;
  assign mag_x      = abs_diff(vertex_x_i, query_x_i);
  assign mag_y      = abs_diff(vertex_y_i, query_y_i);
  assign mag_z      = abs_diff(vertex_z_i, query_z_i);

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (take) begin
      valid_d = 1'b1;
      cnt_d   = last_i ? '0 : idx + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // |diff| <= 2^24, so each square fits 49 bits and the sum never saturates
  always_ff @(posedge clk_i) begin
    if (take) begin
      sq_x_q <= dist_t'(mag_x * mag_x);
      sq_y_q <= dist_t'(mag_y * mag_y);
      sq_z_q <= dist_t'(mag_z * mag_z);
      obj_q  <= object_id_i;
      idx_q  <= idx;
      x_q    <= vertex_x_i;
      y_q    <= vertex_y_i;
      z_q    <= vertex_z_i;
      last_q <= last_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign out_item_o.dist_sq = sq_x_q + sq_y_q + sq_z_q;
  assign out_item_o.obj     = obj_q;
  assign out_item_o.idx     = idx_q;
  assign out_item_o.x       = x_q;
  assign out_item_o.y       = y_q;
  assign out_item_o.z       = z_q;
  assign out_item_o.last    = last_q;

endmodule

// ===== hdl/nvs_queue.sv =====
// ----------------------------------------------------------------------------
// nvs_queue
// Short FIFO between the distance front end and the minimum tracker.
// ----------------------------------------------------------------------------
module nvs_queue import nvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  nvs_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output nvs_item_t pop_item_o
);

  nvs_item_t           mem_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]      count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QDepth))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[QPtrW-1:0])
    else $error("queue pointers disagree with count");
  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

// ===== hdl/nvs_back.sv =====
// ----------------------------------------------------------------------------
// nvs_back
// Tracks the strict minimum distance and its vertex; registers the result on
// the last vertex of a search and restarts the search.
// ----------------------------------------------------------------------------
module nvs_back import nvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nvs_item_t in_item_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output logic      found_o,
  output obj_t      nearest_object_o,
  output idx_t      nearest_index_o,
  output coord_t    nearest_x_o,
  output coord_t    nearest_y_o,
  output coord_t    nearest_z_o,
  output dist_t     min_distance_sq_o
);

  dist_t  best_dist_q, best_dist_d;
  obj_t   best_obj_q, best_obj_d;
  idx_t   best_idx_q, best_idx_d;
  coord_t best_x_q, best_x_d, best_y_q, best_y_d, best_z_q, best_z_d;
  logic   res_valid_q, res_valid_d;
  obj_t   res_obj_q;
  idx_t   res_idx_q;
  coord_t res_x_q, res_y_q, res_z_q;
  dist_t  res_dist_q;
  logic   take, better, emit;
  dist_t  new_dist;
  obj_t   new_obj;
  idx_t   new_idx;
  coord_t new_x, new_y, new_z;

  assign in_ready_o = !in_item_i.last || !res_valid_q || res_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign emit       = take && in_item_i.last;
  assign better     = in_item_i.dist_sq < best_dist_q;
  assign new_dist   = better ? in_item_i.dist_sq : best_dist_q;
  assign new_obj    = better ? in_item_i.obj  : best_obj_q;
  assign new_idx    = better ? in_item_i.idx  : best_idx_q;
  assign new_x      = better ? in_item_i.x    : best_x_q;
  assign new_y      = better ? in_item_i.y    : best_y_q;
  assign new_z      = better ? in_item_i.z    : best_z_q;

  always_comb begin
    best_dist_d = best_dist_q;
    best_obj_d  = best_obj_q;
    best_idx_d  = best_idx_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    best_z_d    = best_z_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (emit) begin
      best_dist_d = DIST_EMPTY;
      best_obj_d  = '0;
      best_idx_d  = '0;
      best_x_d    = '0;
      best_y_d    = '0;
      best_z_d    = '0;
      res_valid_d = 1'b1;
    end else if (take) begin
      best_dist_d = new_dist;
      best_obj_d  = new_obj;
      best_idx_d  = new_idx;
      best_x_d    = new_x;
      best_y_d    = new_y;
      best_z_d    = new_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DIST_EMPTY;
      best_obj_q  <= '0;
      best_idx_q  <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_z_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      best_dist_q <= best_dist_d;
      best_obj_q  <= best_obj_d;
      best_idx_q  <= best_idx_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
      best_z_q    <= best_z_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_obj_q  <= new_obj;
      res_idx_q  <= new_idx;
      res_x_q    <= new_x;
      res_y_q    <= new_y;
      res_z_q    <= new_z;
      res_dist_q <= new_dist;
    end
  end

  // the last vertex is itself scanned, so a result always has a vertex
  assign found_o           = 1'b1;
  assign res_valid_o       = res_valid_q;
  assign nearest_object_o  = res_obj_q;
  assign nearest_index_o   = res_idx_q;
  assign nearest_x_o       = res_x_q;
  assign nearest_y_o       = res_y_q;
  assign nearest_z_o       = res_z_q;
  assign min_distance_sq_o = res_dist_q;

endmodule

// ===== hdl/nearest_vertex_search.sv =====
// Result path: the last vertex passes the front square register, the queue
//   and the result register on its way to the result word.
// Throughput: one vertex word per cycle while nothing stalls, set by the single
//   front multiplier stage and the compare in the minimum tracker.
// Reset: asynchronous, active low; clears query registers, search state,
//   vertex counter, queue and result valid. No clearing pass.
// ----------------------------------------------------------------------------
// nearest_vertex_search
// Linear-scan nearest vertex search by squared Euclidean distance in 3D.
// ----------------------------------------------------------------------------
module nearest_vertex_search import nvs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  cfg_idx_t     cfg_index_i,
  input  coord_t       cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_x[23:0], vertex_y[47:24], vertex_z[71:48], object_id[74:72], zero pad
  input  logic [79:0]  s_axis_tdata,
  // first_of_object
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nearest_object[2:0], nearest_index[22:3], nearest_x[46:23],
  // nearest_y[70:47], nearest_z[94:71], min_distance_sq[144:95], zero pad
  output logic [151:0] m_axis_tdata,
  // found
  output logic         m_axis_tuser
);

  coord_t    query_x_q, query_y_q, query_z_q;
  logic      cfg_we;
  logic      fr_valid, fr_ready, bk_valid, bk_ready;
  nvs_item_t fr_item, bk_item;
  obj_t      res_obj;
  idx_t      res_idx;
  coord_t    res_x, res_y, res_z;
  dist_t     res_dist;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      query_z_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_QUERY_X: query_x_q <= cfg_data_i;
        CFG_QUERY_Y: query_y_q <= cfg_data_i;
        CFG_QUERY_Z: query_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .query_x_i   (query_x_q),
    .query_y_i   (query_y_q),
    .query_z_i   (query_z_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .vertex_x_i  (s_axis_tdata[23:0]),
    .vertex_y_i  (s_axis_tdata[47:24]),
    .vertex_z_i  (s_axis_tdata[71:48]),
    .object_id_i (s_axis_tdata[74:72]),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  nvs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  nvs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (bk_valid),
    .in_ready_o        (bk_ready),
    .in_item_i         (bk_item),
    .res_valid_o       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .found_o           (m_axis_tuser),
    .nearest_object_o  (res_obj),
    .nearest_index_o   (res_idx),
    .nearest_x_o       (res_x),
    .nearest_y_o       (res_y),
    .nearest_z_o       (res_z),
    .min_distance_sq_o (res_dist)
  );

  assign m_axis_tdata = {7'd0, res_dist, res_z, res_y, res_x, res_idx, res_obj};

endmodule

// ===== test/nearest_vertex_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_vertex_search_tb
// Streams vertex searches through the nearest vertex search block and checks
// every result word against a scan predictor kept in the bench. Covers query
// extremes, distance ties, vertex index restarts and random searches,
// with random idle and stall bursts on both stream sides.
// ----------------------------------------------------------------------------
module nearest_vertex_search_tb;
  import nvs_pkg::*;

  localparam int IdleLimit = 2000;
  localparam coord_t CoordMin = coord_t'(24'h800000);
  localparam coord_t CoordMax = coord_t'(24'h7fffff);

  typedef struct packed {
    logic   found;
    obj_t   obj;
    idx_t   idx;
    coord_t x;
    coord_t y;
    coord_t z;
    dist_t  dist_sq;
  } nearest_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  cfg_idx_t     cfg_index_i;
  coord_t       cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;

  // query registers and running scan state of the predictor
  coord_t query_x, query_y, query_z;
  dist_t  best_dist;
  obj_t   best_obj;
  idx_t   best_idx;
  coord_t best_x, best_y, best_z;
  idx_t   vertex_count;
  logic   any_seen;

  nearest_t nearest_q[$];
  int       err_count;
  int       idle_cycles;
  bit       gaps_en;

  nearest_vertex_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor ----
  function automatic dist_t dist_to_query(coord_t x, coord_t y, coord_t z);
    longint dx, dy, dz;
    longint unsigned sum;
    dx = longint'(x) - longint'(query_x);
    dy = longint'(y) - longint'(query_y);
    dz = longint'(z) - longint'(query_z);
    sum = dx * dx + dy * dy + dz * dz;
    if (sum >= DIST_EMPTY) sum = DIST_EMPTY - 1;
    return dist_t'(sum);
  endfunction

  task automatic clear_scan();
    best_dist    = DIST_EMPTY;
    best_obj     = '0;
    best_idx     = '0;
    best_x       = '0;
    best_y       = '0;
    best_z       = '0;
    vertex_count = '0;
    any_seen     = 1'b0;
  endtask

  task automatic scan_vertex(coord_t x, coord_t y, coord_t z, obj_t obj,
                             logic starts_object, logic is_last);
    idx_t     idx;
    dist_t    d;
    nearest_t res;
    idx = starts_object ? idx_t'(0) : vertex_count;
    d   = dist_to_query(x, y, z);
    if (d < best_dist) begin
      best_dist = d;
      best_obj  = obj;
      best_idx  = idx;
      best_x    = x;
      best_y    = y;
      best_z    = z;
    end
    any_seen     = 1'b1;
    vertex_count = idx + 1'b1;
    if (is_last) begin
      res.found   = any_seen;
      res.obj     = best_obj;
      res.idx     = best_idx;
      res.x       = best_x;
      res.y       = best_y;
      res.z       = best_z;
      res.dist_sq = best_dist;
      nearest_q.push_back(res);
      clear_scan();
    end
  endtask

  // ---- result checking ----
  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned exp);
    $display("%0t: MISMATCH %s got 0x%0h exp 0x%0h", $realtime, field, got, exp);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    nearest_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found   = m_axis_tuser;
      got.obj     = m_axis_tdata[2:0];
      got.idx     = m_axis_tdata[22:3];
      got.x       = m_axis_tdata[46:23];
      got.y       = m_axis_tdata[70:47];
      got.z       = m_axis_tdata[94:71];
      got.dist_sq = m_axis_tdata[144:95];
      if (nearest_q.size() == 0) begin
        report_mismatch("unexpected result word", got.dist_sq, 0);
      end else begin
        exp = nearest_q.pop_front();
        if (got.found !== exp.found) report_mismatch("found", got.found, exp.found);
        if (got.obj !== exp.obj) report_mismatch("nearest_object", got.obj, exp.obj);
        if (got.idx !== exp.idx) report_mismatch("nearest_index", got.idx, exp.idx);
        if (got.x !== exp.x) report_mismatch("nearest_x", got.x, exp.x);
        if (got.y !== exp.y) report_mismatch("nearest_y", got.y, exp.y);
        if (got.z !== exp.z) report_mismatch("nearest_z", got.z, exp.z);
        if (got.dist_sq !== exp.dist_sq) begin
          report_mismatch("min_distance_sq", got.dist_sq, exp.dist_sq);
        end
      end
    end
  end

  // ---- receiver stalls ----
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (gaps_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---- drivers ----
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, obj_t obj,
                             logic starts_object, logic is_last);
    @(negedge clk_i);
    if (gaps_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, obj, z, y, x};
    s_axis_tuser  = starts_object;
    s_axis_tlast  = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_vertex(x, y, z, obj, starts_object, is_last);
  endtask

  task automatic release_stream();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_query(cfg_idx_t index, coord_t value);
    release_stream();
    wait_results_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_QUERY_X: query_x = value;
      CFG_QUERY_Y: query_y = value;
      CFG_QUERY_Z: query_z = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_query_point(coord_t x, coord_t y, coord_t z);
    write_query(CFG_QUERY_X, x);
    write_query(CFG_QUERY_Y, y);
    write_query(CFG_QUERY_Z, z);
  endtask

  function automatic coord_t rand_coord(coord_t center);
    case ($urandom_range(0, 7))
      0: return CoordMin;
      1: return CoordMax;
      2, 3, 4: return center + coord_t'($urandom_range(0, 64)) - coord_t'(32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_query_coord();
    case ($urandom_range(0, 3))
      0: return CoordMin;
      1: return CoordMax;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // ---- tests ----
  task automatic test_default_query();
    // query still at reset value (origin)
    send_vertex(coord_t'(5), coord_t'(-3), coord_t'(2), obj_t'(1), 1'b1, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), obj_t'(1), 1'b0, 1'b1);
  endtask

  task automatic test_query_extremes();
    write_query_point(CoordMin, CoordMin, CoordMin);
    send_vertex(CoordMax, CoordMax, CoordMax, obj_t'(0), 1'b1, 1'b1);
    write_query_point(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin, obj_t'(7), 1'b1, 1'b1);
    write_query_point(CoordMax, CoordMin, coord_t'(0));
    send_vertex(CoordMin, CoordMax, coord_t'(0), obj_t'(7), 1'b0, 1'b1);
  endtask

  task automatic test_ties();
    write_query_point(coord_t'(256), coord_t'(512), coord_t'(-256));
    // equal distances: earliest vertex must stay
    send_vertex(coord_t'(266), coord_t'(512), coord_t'(-256), obj_t'(2), 1'b1, 1'b0);
    send_vertex(coord_t'(256), coord_t'(522), coord_t'(-256), obj_t'(2), 1'b0, 1'b0);
    send_vertex(coord_t'(256), coord_t'(512), coord_t'(-266), obj_t'(3), 1'b1, 1'b1);
    send_vertex(coord_t'(259), coord_t'(516), coord_t'(-256), obj_t'(4), 1'b1, 1'b0);
    send_vertex(coord_t'(256), coord_t'(512), coord_t'(-251), obj_t'(4), 1'b0, 1'b0);
    send_vertex(coord_t'(256), coord_t'(512), coord_t'(-256), obj_t'(4), 1'b0, 1'b1);
  endtask

  task automatic test_index_restart();
    // no first marks on the first search: index counts from zero after the previous search
    send_vertex(coord_t'(900), coord_t'(0), coord_t'(0), obj_t'(4), 1'b0, 1'b0);
    send_vertex(coord_t'(600), coord_t'(0), coord_t'(0), obj_t'(4), 1'b0, 1'b0);
    send_vertex(coord_t'(300), coord_t'(512), coord_t'(-256), obj_t'(4), 1'b0, 1'b1);
    send_vertex(coord_t'(-900), coord_t'(0), coord_t'(0), obj_t'(5), 1'b0, 1'b0);
    send_vertex(coord_t'(-800), coord_t'(0), coord_t'(0), obj_t'(6), 1'b1, 1'b0);
    send_vertex(coord_t'(-100), coord_t'(500), coord_t'(0), obj_t'(6), 1'b0, 1'b0);
    send_vertex(coord_t'(250), coord_t'(510), coord_t'(-250), obj_t'(6), 1'b0, 1'b1);
  endtask

  task automatic test_random_scan();
    coord_t seen_x[$], seen_y[$], seen_z[$];
    coord_t x, y, z;
    obj_t   obj;
    logic   starts_object;
    int     sent, len, pick;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) gaps_en = 1'b0;
      if (phase > 0) write_query_point(rand_query_coord(), rand_query_coord(),
                                       rand_query_coord());
      sent = 0;
      while (sent < 100) begin
        if (phase == 2 && sent >= 50 && sent < 62) begin
          // hold the stream until every pending result is back
          release_stream();
          wait_results_drained();
          sent = 62;
        end
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        obj = obj_t'($urandom);
        seen_x.delete();
        seen_y.delete();
        seen_z.delete();
        for (int i = 0; i < len; i++) begin
          starts_object = (i == 0) ? ($urandom_range(0, 3) != 0) : 1'b0;
          if (i > 0 && $urandom_range(0, 4) == 0) begin
            starts_object = 1'b1;
            obj = obj_t'($urandom);
          end
          if (seen_x.size() > 0 && $urandom_range(0, 6) == 0) begin
            pick = $urandom_range(0, seen_x.size() - 1);
            x = seen_x[pick];
            y = seen_y[pick];
            z = seen_z[pick];
          end else begin
            x = rand_coord(query_x);
            y = rand_coord(query_y);
            z = rand_coord(query_z);
          end
          seen_x.push_back(x);
          seen_y.push_back(y);
          seen_z.push_back(z);
          send_vertex(x, y, z, obj, starts_object, i == len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_QUERY_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    err_count     = 0;
    idle_cycles   = 0;
    gaps_en       = 1'b1;
    query_x       = '0;
    query_y       = '0;
    query_z       = '0;
    clear_scan();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_query();
    test_query_extremes();
    test_ties();
    test_index_restart();
    test_random_scan();

    release_stream();
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nvs_pkg.sv
hdl/nvs_front.sv
hdl/nvs_queue.sv
hdl/nvs_back.sv
hdl/nearest_vertex_search.sv
test/nearest_vertex_search_tb.sv
